// File: rtl/coalescing_event_ring_queue_assert.svh
// Assertion macros for the coalescing event ring queue checker.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef COALESCING_EVENT_RING_QUEUE_ASSERT_SVH
`define COALESCING_EVENT_RING_QUEUE_ASSERT_SVH

// Same-cycle implication
`define CERQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CERQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/cerq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cerq_pkg;

   // Field widths
   localparam int KEY_W    = 32;
   localparam int TYPE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int DROPS_W  = 16;
   localparam int CSR_W    = 5;
   localparam int CSR_IDX_W = 2;

   // One drain emits at most this many results
   localparam logic [COUNT_W-1:0] MAX_RESULTS = 5'd16;

   // Register reset values
   localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;
   localparam logic               COALESCE_RESET = 1'b1;
   localparam logic               DROP_MODE_RESET = 1'b0;

   // Saturation point of the drop counter
   localparam logic [DROPS_W-1:0] DROPS_MAX = '1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY  = 2'd0,
      CSR_COALESCE  = 2'd1,
      CSR_DROP_MODE = 2'd2
   } csr_index_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_QUEUED    = 3'd0,
      ST_COALESCED = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_FULL      = 3'd3,
      ST_INVALID   = 3'd4
   } status_type;

   // One queue entry as stored in the ring
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [TYPE_W-1:0]  tag;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;        // latch the request, start a scan
      logic       rd;          // read ring at scan pointer, advance it
      logic       push;        // write request at tail
      logic       drop;        // discard head, count a drop
      logic       pop;         // discard head after a drain read
      logic       emit;        // present a result
      logic       emit_entry;  // result carries the read entry
      logic       emit_last;   // final result of the transaction
      status_type status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_drain;
      logic invalid;
      logic coal_en;
      logic scan_more;
      logic match;
      logic at_limit;
      logic drop_mode;
      logic empty;
      logic drain_more;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/cerq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module cerq_dpath import cerq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output stat_type                        stat,
   input  wire logic                       req_kind,
   input  wire logic [KEY_W-1:0]           req_event_key,
   input  wire logic [TYPE_W-1:0]          req_value_type,
   input  wire logic signed [VALUE_W-1:0]  req_event_value,
   input  wire logic [COUNT_W-1:0]         req_drain_limit,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   output logic                            rsp_strobe,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_out_valid,
   output logic [KEY_W-1:0]                rsp_out_key,
   output logic [TYPE_W-1:0]               rsp_out_type,
   output logic signed [VALUE_W-1:0]       rsp_out_value,
   output logic                            rsp_last,
   output logic [COUNT_W-1:0]              rsp_queued_count,
   output logic [DROPS_W-1:0]              rsp_drops_total
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] DEPTH_CLAMP =
      (QUEUE_DEPTH > 31) ? 5'd31 : COUNT_W'(QUEUE_DEPTH);

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // Configuration
   logic [COUNT_W-1:0] cap_ff;
   logic               coal_ff;
   logic               drop_mode_ff;

   // Ring control
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [DROPS_W-1:0] drops_ff, drops_in;

   // Scan / drain sequencing
   logic [AW-1:0]      scan_ptr_ff;
   logic [COUNT_W-1:0] scan_cnt_ff;
   logic [COUNT_W-1:0] remain_ff;

   // Latched transaction
   logic               kind_ff;
   entry_type          item_ff;

   // Ring storage and its registered read port
   entry_type          ring_mem [QUEUE_DEPTH];
   entry_type          rd_data_ff;

   // Result registers
   logic               rsp_strobe_ff;
   status_type         rsp_status_ff;
   logic               rsp_valid_ff;
   entry_type          rsp_entry_ff;
   logic               rsp_last_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [DROPS_W-1:0] rsp_drops_ff;

   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] drain_n;
   logic               head_move;

   // Effective capacity: the register clamped to the ring depth
   assign limit = (int'(cap_ff) > QUEUE_DEPTH) ? DEPTH_CLAMP : cap_ff;

   // Entries a drain will emit
   always_comb begin
      drain_n = count_ff;
      if (req_drain_limit != '0 && req_drain_limit < drain_n) begin
         drain_n = req_drain_limit;
      end
      if (drain_n > MAX_RESULTS) begin
         drain_n = MAX_RESULTS;
      end
   end

   // Pointer, count and drop counter next values
   assign head_move = cmd.drop | cmd.pop;

   always_comb begin
      head_in  = head_move ? ring_next(head_ff) : head_ff;
      tail_in  = cmd.push ? ring_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (cmd.push && !head_move) begin
         count_in = count_ff + 1'b1;
      end else if (head_move && !cmd.push) begin
         count_in = count_ff - 1'b1;
      end
      drops_in = drops_ff;
      if (cmd.drop && drops_ff != DROPS_MAX) begin
         drops_in = drops_ff + 1'b1;
      end
   end

   // Status toward the controller
   always_comb begin
      stat.is_drain   = kind_ff;
      stat.invalid    = (item_ff.key == '0) || (limit == '0);
      stat.coal_en    = coal_ff;
      stat.scan_more  = scan_cnt_ff < count_ff;
      stat.match      = (rd_data_ff == item_ff);
      stat.at_limit   = count_ff >= limit;
      stat.drop_mode  = drop_mode_ff;
      stat.empty      = (count_ff == '0);
      stat.drain_more = remain_ff > 5'd1;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAPACITY_RESET;
         coal_ff       <= COALESCE_RESET;
         drop_mode_ff  <= DROP_MODE_RESET;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         drops_ff      <= '0;
         scan_ptr_ff   <= '0;
         scan_cnt_ff   <= '0;
         remain_ff     <= '0;
         kind_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CAPACITY:  cap_ff       <= csr_wdata;
               CSR_COALESCE:  coal_ff      <= csr_wdata[0];
               CSR_DROP_MODE: drop_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         drops_ff      <= drops_in;
         rsp_strobe_ff <= cmd.emit;
         if (cmd.load) begin
            kind_ff     <= req_kind;
            scan_ptr_ff <= head_ff;
            scan_cnt_ff <= '0;
            remain_ff   <= drain_n;
         end else begin
            if (cmd.rd) begin
               scan_ptr_ff <= ring_next(scan_ptr_ff);
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
            end
            if (cmd.pop) begin
               remain_ff <= remain_ff - 1'b1;
            end
         end
      end
   end

   // Latched request fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff.key   <= req_event_key;
         item_ff.tag   <= req_value_type;
         item_ff.value <= req_event_value;
      end
   end

   // Ring memory: one write at tail, one registered read at scan pointer
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ring_mem[tail_ff] <= item_ff;
      end
      if (cmd.rd) begin
         rd_data_ff <= ring_mem[scan_ptr_ff];
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         rsp_valid_ff  <= cmd.emit_entry;
         rsp_entry_ff  <= cmd.emit_entry ? rd_data_ff : '0;
         rsp_last_ff   <= cmd.emit_last;
         rsp_count_ff  <= count_in;
         rsp_drops_ff  <= drops_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_valid    = rsp_valid_ff;
   assign rsp_out_key      = rsp_entry_ff.key;
   assign rsp_out_type     = rsp_entry_ff.tag;
   assign rsp_out_value    = rsp_entry_ff.value;
   assign rsp_last         = rsp_last_ff;
   assign rsp_queued_count = rsp_count_ff;
   assign rsp_drops_total  = rsp_drops_ff;

endmodule

`default_nettype wire

// File: rtl/cerq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cerq_ctrl import cerq_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   output logic          busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DECIDE,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.status     = ST_QUEUED;
      cmd.emit_last  = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_drain) begin
               if (stat.empty) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.rd   = 1'b1;
                  state_in = S_DRAIN;
               end
            end else if (stat.invalid) begin
               cmd.emit   = 1'b1;
               cmd.status = ST_INVALID;
               state_in   = S_IDLE;
            end else if (stat.coal_en && stat.scan_more) begin
               cmd.rd   = 1'b1;
               state_in = S_SCAN;
            end else begin
               state_in = S_DECIDE;
            end
         end
         // one queued entry compared per cycle
         S_SCAN: begin
            if (stat.match) begin
               cmd.emit   = 1'b1;
               cmd.status = ST_COALESCED;
               state_in   = S_IDLE;
            end else if (stat.scan_more) begin
               cmd.rd = 1'b1;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
            if (stat.at_limit) begin
               if (!stat.drop_mode || stat.empty) begin
                  cmd.status = ST_FULL;
               end else begin
                  cmd.drop   = 1'b1;
                  cmd.push   = 1'b1;
                  cmd.status = ST_DROPPED;
               end
            end else begin
               cmd.push = 1'b1;
            end
         end
         // one entry emitted per cycle, next read overlapped
         S_DRAIN: begin
            cmd.emit       = 1'b1;
            cmd.emit_entry = 1'b1;
            cmd.pop        = 1'b1;
            if (stat.drain_more) begin
               cmd.rd        = 1'b1;
               cmd.emit_last = 1'b0;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// File: rtl/coalescing_event_ring_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Coalescing event ring queue: a bounded FIFO of keyed events.
// Request channel: drive req_* and pulse start while busy is low; the transaction is
// taken on that edge. req_kind 0 enqueues one event, 1 drains up to req_drain_limit
// entries (0 drains everything queued, never more than 16 per drain).
// Result channel: each result shows on rsp_* for one cycle with rsp_strobe high;
// rsp_last marks the final result of the transaction. The receiver cannot stall.
// Configuration: csr_we with csr_index / csr_wdata, only while busy is low.
// Sequence: an enqueue that needs no scan passes the check state and answers from
// the decide state; one rejected as invalid answers from the check state. With
// coalescing on, a scan compares the queued entries in order from the head, answers
// on the first match and otherwise goes on to the decide state. A drain reads the
// head first and then gives one result per cycle; an empty drain answers from the
// check state. The ring's single registered read port sets the scan and drain rate.
// busy drops in the cycle the last result shows, so a new request may be taken then.
// Reset (synchronous) empties the queue, clears the drop counter and loads the
// registers with capacity 16, coalescing on, reject-new on full. No clearing pass.
module coalescing_event_ring_queue import cerq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_kind,
   input  wire logic [KEY_W-1:0]           req_event_key,
   input  wire logic [TYPE_W-1:0]          req_value_type,
   input  wire logic signed [VALUE_W-1:0]  req_event_value,
   input  wire logic [COUNT_W-1:0]         req_drain_limit,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]           csr_wdata,
   output logic                            rsp_strobe,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_out_valid,
   output logic [KEY_W-1:0]                rsp_out_key,
   output logic [TYPE_W-1:0]               rsp_out_type,
   output logic signed [VALUE_W-1:0]       rsp_out_value,
   output logic                            rsp_last,
   output logic [COUNT_W-1:0]              rsp_queued_count,
   output logic [DROPS_W-1:0]              rsp_drops_total
);

   cmd_type  cmd;
   stat_type stat;

   cerq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cerq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_event_key    (req_event_key),
      .req_value_type   (req_value_type),
      .req_event_value  (req_event_value),
      .req_drain_limit  (req_drain_limit),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_type     (rsp_out_type),
      .rsp_out_value    (rsp_out_value),
      .rsp_last         (rsp_last),
      .rsp_queued_count (rsp_queued_count),
      .rsp_drops_total  (rsp_drops_total)
   );

endmodule

`default_nettype wire

// File: rtl/cerq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "coalescing_event_ring_queue_assert.svh"

module cerq_checker import cerq_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_out_valid,
   input wire logic       rsp_last
);

   // An accepted transaction keeps the block busy in the next cycle
   `CERQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

   // Busy ends only with the final result of the transaction
   `CERQ_ASSERT_NOW(a_busy_end, $fell(busy), rsp_strobe && rsp_last, "busy fell without last")

   // Results without an entry are always single and final
   `CERQ_ASSERT_NOW(a_plain_last, rsp_strobe && !rsp_out_valid, rsp_last,
                    "entryless result not marked last")

   // Drained entries carry the neutral status
   `CERQ_ASSERT_NOW(a_drain_status, rsp_strobe && rsp_out_valid, rsp_status == ST_QUEUED,
                    "drained entry with nonzero status")

   // A drain streams its results in back-to-back cycles
   `CERQ_ASSERT_NEXT(a_drain_stream, rsp_strobe && !rsp_last, rsp_strobe,
                     "gap inside a drain burst")

endmodule

bind coalescing_event_ring_queue cerq_checker u_cerq_checker (.*);

`default_nettype wire

// File: dv/coalescing_event_ring_queue_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports of the event ring queue,
// keeps its own copy of the queue and compares every result in order.
module coalescing_event_ring_queue_checker import cerq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_kind,
   input  logic [KEY_W-1:0]          req_event_key,
   input  logic [TYPE_W-1:0]         req_value_type,
   input  logic [VALUE_W-1:0]        req_event_value,
   input  logic [COUNT_W-1:0]        req_drain_limit,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   input  logic                      rsp_strobe,
   input  logic [2:0]                rsp_status,
   input  logic                      rsp_out_valid,
   input  logic [KEY_W-1:0]          rsp_out_key,
   input  logic [TYPE_W-1:0]         rsp_out_type,
   input  logic [VALUE_W-1:0]        rsp_out_value,
   input  logic                      rsp_last,
   input  logic [COUNT_W-1:0]        rsp_queued_count,
   input  logic [DROPS_W-1:0]        rsp_drops_total,
   output int                        fail_count,
   output int                        pending,
   output int                        checked_count
);

   localparam int DEPTH = 16;

   // One expected result
   typedef struct packed {
      status_type          status;
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [TYPE_W-1:0]   tag;
      logic [VALUE_W-1:0]  value;
      logic                last;
      logic [COUNT_W-1:0]  count;
      logic [DROPS_W-1:0]  drops;
   } result_type;

   result_type         queued_results[$];

   // Shadow of the ring and its registers
   entry_type          ring_entry [DEPTH];
   logic [3:0]         head_ptr;
   logic [3:0]         tail_ptr;
   logic [COUNT_W-1:0] entry_count;
   logic [DROPS_W-1:0] drop_count;
   logic [CSR_W-1:0]   capacity_reg;
   logic               coalesce_reg;
   logic               drop_mode_reg;

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked_count = 0;
   end

   task automatic clear_queue();
      for (int i = 0; i < DEPTH; i++) ring_entry[i] = '0;
      head_ptr      = '0;
      tail_ptr      = '0;
      entry_count   = '0;
      drop_count    = '0;
      capacity_reg  = CAPACITY_RESET;
      coalesce_reg  = COALESCE_RESET;
      drop_mode_reg = DROP_MODE_RESET;
      queued_results.delete();
   endtask

   task automatic add_result(input status_type st, input logic valid, input entry_type e,
                             input logic last);
      result_type r;
      r.status = st;
      r.valid  = valid;
      r.key    = e.key;
      r.tag    = e.tag;
      r.value  = e.value;
      r.last   = last;
      r.count  = entry_count;
      r.drops  = drop_count;
      queued_results.push_back(r);
   endtask

   function automatic entry_type take_head();
      entry_type e;
      e = ring_entry[head_ptr];
      ring_entry[head_ptr] = '0;
      head_ptr++;
      entry_count--;
      return e;
   endfunction

   // Enqueue: validity, coalescing scan, full policy, then push at tail
   task automatic apply_enqueue(input entry_type ev);
      int         limit;
      logic       hit;
      status_type st;
      limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
      st    = ST_QUEUED;
      hit   = 1'b0;
      if (ev.key == '0 || limit == 0) begin
         st = ST_INVALID;
      end else begin
         if (coalesce_reg) begin
            for (int i = 0; i < entry_count; i++)
               if (ring_entry[4'(head_ptr + i)] == ev) hit = 1'b1;
         end
         if (hit) begin
            st = ST_COALESCED;
         end else if (entry_count >= limit && !drop_mode_reg) begin
            st = ST_FULL;
         end else begin
            if (entry_count >= limit) begin
               void'(take_head());
               if (drop_count != DROPS_MAX) drop_count++;
               st = ST_DROPPED;
            end
            ring_entry[tail_ptr] = ev;
            tail_ptr++;
            entry_count++;
         end
      end
      add_result(st, 1'b0, '0, 1'b1);
   endtask

   // Drain: pop up to the limit, never more than one burst of MAX_RESULTS
   task automatic apply_drain(input logic [COUNT_W-1:0] dlim);
      int        n;
      entry_type e;
      if (entry_count == '0) begin
         add_result(ST_QUEUED, 1'b0, '0, 1'b1);
      end else begin
         n = entry_count;
         if (dlim != '0 && dlim < n) n = dlim;
         if (n > MAX_RESULTS) n = MAX_RESULTS;
         for (int k = 0; k < n; k++) begin
            e = take_head();
            add_result(ST_QUEUED, 1'b1, e, k == n - 1);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type exp_r;
      entry_type  ev;
      if (reset) begin
         clear_queue();
      end else begin
         // Result side: compare against the oldest expectation
         if (rsp_strobe === 1'b1) begin
            checked_count++;
            if (queued_results.size() == 0) begin
               $error("result with no transaction outstanding (status 0x%0h, key 0x%0h)",
                      rsp_status, rsp_out_key);
               fail_count++;
            end else begin
               exp_r = queued_results.pop_front();
               check_field("status", exp_r.status, rsp_status);
               check_field("out_valid", exp_r.valid, rsp_out_valid);
               check_field("out_key", exp_r.key, rsp_out_key);
               check_field("out_type", exp_r.tag, rsp_out_type);
               check_field("out_value", exp_r.value, rsp_out_value);
               check_field("last", exp_r.last, rsp_last);
               check_field("queued_count", exp_r.count, rsp_queued_count);
               check_field("drops_total", exp_r.drops, rsp_drops_total);
            end
         end

         // Register writes
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_CAPACITY:  capacity_reg  = csr_wdata;
               CSR_COALESCE:  coalesce_reg  = csr_wdata[0];
               CSR_DROP_MODE: drop_mode_reg = csr_wdata[0];
               default: ;
            endcase
         end

         // Accepted transaction
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_kind) begin
               apply_drain(req_drain_limit);
            end else begin
               ev.key   = req_event_key;
               ev.tag   = req_value_type;
               ev.value = req_event_value;
               apply_enqueue(ev);
            end
         end
      end
      pending = queued_results.size();
   end

endmodule

// File: dv/coalescing_event_ring_queue_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the event ring queue; all checking is in the checker.
module coalescing_event_ring_queue_tb;
   import cerq_pkg::*;

   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 17;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_kind = 1'b0;
   logic [KEY_W-1:0]          req_event_key = '0;
   logic [TYPE_W-1:0]         req_value_type = '0;
   logic signed [VALUE_W-1:0] req_event_value = '0;
   logic [COUNT_W-1:0]        req_drain_limit = '0;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_CAPACITY;
   logic [CSR_W-1:0]          csr_wdata = '0;
   logic                      rsp_strobe;
   logic [2:0]                rsp_status;
   logic                      rsp_out_valid;
   logic [KEY_W-1:0]          rsp_out_key;
   logic [TYPE_W-1:0]         rsp_out_type;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic                      rsp_last;
   logic [COUNT_W-1:0]        rsp_queued_count;
   logic [DROPS_W-1:0]        rsp_drops_total;

   int fail_count;
   int pending;
   int checked_count;
   int enqueue_count = 0;
   int drain_count   = 0;
   int setting_count = 0;
   int idle_pct      = 0;

   // Register settings of the random phases, with the sender idle rate of each
   int phase_cap  [NUM_PHASES] = '{16, 4, 1, 31, 0, 3, 16, 2};
   int phase_coal [NUM_PHASES] = '{1, 1, 0, 0, 1, 1, 1, 0};
   int phase_drop [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 1, 1};
   int phase_idle [NUM_PHASES] = '{0, 88, 0, 31, 88, 31, 0, 88};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   coalescing_event_ring_queue i_dut (.*);

   coalescing_event_ring_queue_checker i_checker (.*);

   // Present one transaction and hold it until the block takes it
   task automatic send(input logic kind, input logic [KEY_W-1:0] key,
                       input logic [TYPE_W-1:0] tag, input logic [VALUE_W-1:0] value,
                       input logic [COUNT_W-1:0] dlim);
      start           <= 1'b1;
      req_kind        <= kind;
      req_event_key   <= key;
      req_value_type  <= tag;
      req_event_value <= value;
      req_drain_limit <= dlim;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind) drain_count++;
      else enqueue_count++;
      // random gap after the transaction
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic enqueue(input logic [KEY_W-1:0] key, input logic [TYPE_W-1:0] tag,
                          input logic [VALUE_W-1:0] value);
      send(1'b0, key, tag, value, 5'($urandom));
   endtask

   task automatic drain(input logic [COUNT_W-1:0] dlim);
      send(1'b1, $urandom, 3'($urandom), $urandom, dlim);
   endtask

   // Stop sending and wait until every expected result has come
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (24) @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_W-1:0] cap, input logic coal,
                             input logic drop);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      csr_index <= CSR_COALESCE;
      csr_wdata <= CSR_W'(coal);
      @(posedge clock);
      csr_index <= CSR_DROP_MODE;
      csr_wdata <= CSR_W'(drop);
      @(posedge clock);
      csr_we    <= 1'b0;
      setting_count++;
   endtask

   // Mostly small key, tag and value pools so that coalescing and refills happen
   task automatic random_item();
      logic [KEY_W-1:0]   key;
      logic [TYPE_W-1:0]  tag;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] dlim;
      int                 r;
      r = $urandom_range(99);
      if (r < 5) key = '0;
      else if (r < 80) key = $urandom_range(1, 4);
      else key = $urandom;
      tag = ($urandom_range(99) < 70) ? 3'($urandom_range(0, 1)) : 3'($urandom);
      case ($urandom_range(0, 5))
         0: value = '0;
         1: value = '1;
         2: value = 32'h8000_0000;
         default: value = $urandom;
      endcase
      dlim = ($urandom_range(1) == 0) ? 5'($urandom_range(0, 4)) : 5'($urandom);
      if ($urandom_range(99) < 22) send(1'b1, key, tag, value, dlim);
      else send(1'b0, key, tag, value, dlim);
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty drain, invalid key, extremes, coalescing
      drain(5'd0);
      enqueue('0, 3'd7, 32'h8000_0000);
      enqueue('1, 3'd7, 32'h7FFF_FFFF);
      enqueue(32'd1, 3'd0, 32'h8000_0000);
      enqueue(32'd1, 3'd0, 32'h8000_0000);
      enqueue(32'd1, 3'd1, 32'h8000_0000);
      drain(5'd1);
      drain(5'd0);

      // Fill to depth, overflow with reject-new, then drop-oldest above the limit
      for (int i = 0; i < 16; i++) enqueue(32'h100 + i, 3'(i), 32'(i));
      enqueue(32'h200, 3'd2, 32'd7);
      set_config(5'd2, 1'b1, 1'b1);
      enqueue(32'h201, 3'd3, 32'd8);
      drain(5'd31);

      // Zero capacity rejects, capacity above depth acts as depth
      set_config(5'd0, 1'b1, 1'b0);
      enqueue(32'h300, 3'd0, 32'd1);
      set_config(5'd31, 1'b1, 1'b0);
      enqueue(32'h301, 3'd5, 32'hFFFF_FFFF);
      enqueue(32'h301, 3'd5, 32'hFFFF_FFFF);
      drain(5'd0);

      // Random phases over several register settings
      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = 0;
         set_config(5'(phase_cap[p]), phase_coal[p][0], phase_drop[p][0]);
         idle_pct = phase_idle[p];
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
      end

      // Empty whatever is left
      idle_pct = 0;
      drain(5'd0);

      // Wait out all remaining results
      start <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      @(negedge clock);

      $display("Ran %0d enqueues and %0d drains over %0d register settings, %0d results checked,",
               enqueue_count, drain_count, setting_count, checked_count);
      $display("including empty drains, invalid keys, coalescing and both full-queue policies.");
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending != 0) $error("%0d expected results never arrived", pending);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(20_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
